// ===== hdl/stok_pkg.sv =====
// shared types, constants and character-class functions for the source tokenizer
package stok_pkg;

  localparam int POSITION_BITS = 24;
  localparam int RES_W = 24;
  localparam int CODE_W = 5;
  localparam int RES_MAX = 3;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);
  localparam int TDATA_W = 56;

  typedef enum logic [2:0] {
    K_PREFIXED = 3'd0,
    K_INT      = 3'd1,
    K_IDENT    = 3'd2,
    K_CHAR     = 3'd3,
    K_STRING   = 3'd4,
    K_PUNCT    = 3'd5,
    K_END      = 3'd6,
    K_ERROR    = 3'd7
  } kind_e;

  localparam logic [CODE_W-1:0] PC_ARROW = 5'd0;
  localparam logic [CODE_W-1:0] PC_SHL   = 5'd1;
  localparam logic [CODE_W-1:0] PC_SHR   = 5'd2;
  localparam logic [CODE_W-1:0] PC_LE    = 5'd3;
  localparam logic [CODE_W-1:0] PC_GE    = 5'd4;
  localparam logic [CODE_W-1:0] PC_NONE  = 5'd0;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef struct packed {
    kind_e             kind;
    logic [RES_W-1:0]  start;
    logic [RES_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic              last;
  } res_t;

  function automatic res_t mk_res(kind_e kind, logic [RES_W-1:0] start,
                                  logic [RES_W-1:0] len, logic [CODE_W-1:0] code,
                                  logic last);
    res_t r;
    r.kind  = kind;
    r.start = start;
    r.len   = len;
    r.code  = code;
    r.last  = last;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // one-character punctuator code, bit 5 set when the byte is one
  function automatic logic [CODE_W:0] single_code(logic [7:0] c);
    logic [CODE_W:0] r;
    case (c)
      "<":     r = {1'b1, 5'd5};
      ">":     r = {1'b1, 5'd6};
      "+":     r = {1'b1, 5'd7};
      "-":     r = {1'b1, 5'd8};
      "/":     r = {1'b1, 5'd9};
      "*":     r = {1'b1, 5'd10};
      "%":     r = {1'b1, 5'd11};
      "=":     r = {1'b1, 5'd12};
      ";":     r = {1'b1, 5'd13};
      ":":     r = {1'b1, 5'd14};
      ",":     r = {1'b1, 5'd15};
      ".":     r = {1'b1, 5'd16};
      "[":     r = {1'b1, 5'd17};
      "]":     r = {1'b1, 5'd18};
      "(":     r = {1'b1, 5'd19};
      ")":     r = {1'b1, 5'd20};
      "{":     r = {1'b1, 5'd21};
      "}":     r = {1'b1, 5'd22};
      "!":     r = {1'b1, 5'd23};
      "?":     r = {1'b1, 5'd24};
      "&":     r = {1'b1, 5'd25};
      "^":     r = {1'b1, 5'd26};
      "|":     r = {1'b1, 5'd27};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/source_tokenizer_top.sv =====
// top level of the source tokenizer: input register, scanner and token queue
//
//  channel   dir  tdata                                   tuser    tlast
//  s_axis    in   [7:0] source byte                       -        final byte
//  m_axis    out  [23:0] start [47:24] length [52:48] code [2:0] kind last token
//
//  one byte per cycle is taken while the queue has room; a byte yields up to three tokens
//  input stalls while more than one token would stay queued after the current read
//  each byte is registered at the input and its tokens are registered in the queue
//  the byte register frees while tokens still wait in the four-entry queue
//  reset clears scanner state and empties the queue
module source_tokenizer_top #(
  parameter int PosW = stok_pkg::POSITION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] byte_in
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [stok_pkg::TDATA_W-1:0] m_axis_tdata,   // start_res, length, punct_code
  output logic [2:0]                   m_axis_tuser,   // kind
  output logic                         m_axis_tlast
);

  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           in_last_q;
  logic           fire;
  logic           room;
  logic [1:0]     res_cnt;
  logic [1:0]     push_cnt;
  stok_pkg::res_t [stok_pkg::RES_MAX-1:0] res;
  stok_pkg::res_t out_res;

  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || fire;
  assign push_cnt      = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  stok_scan #(
    .PosW(PosW)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  stok_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push_data_i(res),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.code, out_res.len, out_res.start};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

// ===== hdl/stok_scan.sv =====
// scanner state and per-byte next-state logic producing up to three tokens
module stok_scan #(
  parameter int PosW = stok_pkg::POSITION_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [7:0]                          byte_i,
  input  logic                                last_i,
  output stok_pkg::res_t [stok_pkg::RES_MAX-1:0] res_o,
  output logic [1:0]                          res_cnt_o
);

  localparam int ResW = stok_pkg::RES_W;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [PosW-1:0] PosOne = PosW'(1);

  typedef enum logic [7:0] {
    M_IDLE   = 8'b0000_0001,
    M_HEX    = 8'b0000_0010,
    M_BIN    = 8'b0000_0100,
    M_INT    = 8'b0000_1000,
    M_IDENT  = 8'b0001_0000,
    M_CHAR   = 8'b0010_0000,
    M_STRING = 8'b0100_0000,
    M_PUNCT  = 8'b1000_0000
  } scan_mode_e;

  scan_mode_e      mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] tstart_q, tstart_d;
  logic [7:0]      hbyte_q, hbyte_d;
  logic            hvalid_q, hvalid_d;
  logic            halted_q, halted_d;

  stok_pkg::res_t [stok_pkg::RES_MAX-1:0] res_d;
  logic [1:0]      n;
  logic            used;
  logic            done;
  logic            wipe;
  logic [PosW-1:0] p_inc;
  logic [stok_pkg::CODE_W:0] sc_in;
  logic [stok_pkg::CODE_W:0] sc_held;

  function automatic stok_pkg::kind_e word_kind(scan_mode_e m);
    stok_pkg::kind_e k;
    case (m)
      M_HEX, M_BIN: k = stok_pkg::K_PREFIXED;
      M_INT:        k = stok_pkg::K_INT;
      default:      k = stok_pkg::K_IDENT;
    endcase
    return k;
  endfunction

  assign p_inc = pos_q + PosOne;
  assign sc_in = stok_pkg::single_code(byte_i);

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    tstart_d = tstart_q;
    hbyte_d  = hbyte_q;
    hvalid_d = hvalid_q;
    halted_d = halted_q;
    res_d    = '0;
    n        = '0;
    used     = 1'b0;
    done     = 1'b0;
    wipe     = 1'b0;
    sc_held  = '0;

    if (halted_q) begin
      done = 1'b1;
      if (last_i) begin
        res_d[n] = stok_pkg::mk_res(stok_pkg::K_ERROR, ResW'(tstart_q), '0,
                                    stok_pkg::PC_NONE, 1'b1);
        n = n + 2'd1;
        wipe = 1'b1;
      end
    end else if (pos_q == PosMax) begin
      done = 1'b1;
      res_d[n] = stok_pkg::mk_res(stok_pkg::K_ERROR, ResW'(pos_q), '0,
                                  stok_pkg::PC_NONE, last_i);
      n = n + 2'd1;
      if (last_i) begin
        wipe = 1'b1;
      end else begin
        mode_d   = M_IDLE;
        hvalid_d = 1'b0;
        halted_d = 1'b1;
        tstart_d = pos_q;
      end
    end else begin
      case (mode_q)
        M_HEX, M_BIN, M_INT, M_IDENT: begin
          if (mode_q == M_INT && hvalid_q && (byte_i == "x" || byte_i == "b")) begin
            mode_d = (byte_i == "x") ? M_HEX : M_BIN;
            used   = 1'b1;
          end else if ((mode_q == M_HEX && stok_pkg::is_hex(byte_i)) ||
                       (mode_q == M_BIN && (byte_i == "0" || byte_i == "1")) ||
                       (mode_q == M_INT && stok_pkg::is_digit(byte_i)) ||
                       (mode_q == M_IDENT && stok_pkg::is_word(byte_i))) begin
            used = 1'b1;
          end else begin
            res_d[n] = stok_pkg::mk_res(word_kind(mode_q), ResW'(tstart_q),
                                        ResW'(pos_q - tstart_q), stok_pkg::PC_NONE, 1'b0);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end
          hvalid_d = 1'b0;
        end
        M_CHAR, M_STRING: begin
          used = 1'b1;
          if (byte_i == ((mode_q == M_CHAR) ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE)) begin
            res_d[n] = stok_pkg::mk_res(
              (mode_q == M_CHAR) ? stok_pkg::K_CHAR : stok_pkg::K_STRING,
              ResW'(tstart_q), ResW'(pos_q - tstart_q), stok_pkg::PC_NONE, 1'b0);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end
        end
        M_PUNCT: begin
          used = 1'b1;
          if (hbyte_q == "-" && byte_i == ">") begin
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(tstart_q), ResW'(2),
                                        stok_pkg::PC_ARROW, 1'b0);
          end else if (hbyte_q == "<" && byte_i == "<") begin
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(tstart_q), ResW'(2),
                                        stok_pkg::PC_SHL, 1'b0);
          end else if (hbyte_q == ">" && byte_i == ">") begin
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(tstart_q), ResW'(2),
                                        stok_pkg::PC_SHR, 1'b0);
          end else if (hbyte_q == "<" && byte_i == "=") begin
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(tstart_q), ResW'(2),
                                        stok_pkg::PC_LE, 1'b0);
          end else if (hbyte_q == ">" && byte_i == "=") begin
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(tstart_q), ResW'(2),
                                        stok_pkg::PC_GE, 1'b0);
          end else begin
            used = 1'b0;
            sc_held = stok_pkg::single_code(hbyte_q);
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(tstart_q), ResW'(1),
                                        sc_held[stok_pkg::CODE_W-1:0], 1'b0);
          end
          n = n + 2'd1;
          mode_d = M_IDLE;
        end
        default: ;
      endcase

      if (!used) begin
        tstart_d = pos_q;
        if (stok_pkg::is_space(byte_i)) begin
          mode_d = mode_d;
        end else if (stok_pkg::is_digit(byte_i)) begin
          mode_d   = M_INT;
          hvalid_d = (byte_i == "0");
        end else if (stok_pkg::is_alpha(byte_i) || byte_i == "_") begin
          mode_d = M_IDENT;
        end else if (byte_i == stok_pkg::CH_SQUOTE || byte_i == stok_pkg::CH_DQUOTE) begin
          mode_d   = (byte_i == stok_pkg::CH_SQUOTE) ? M_CHAR : M_STRING;
          tstart_d = p_inc;
        end else if (byte_i == "-" || byte_i == "<" || byte_i == ">") begin
          mode_d  = M_PUNCT;
          hbyte_d = byte_i;
        end else if (sc_in[stok_pkg::CODE_W]) begin
          res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(pos_q), ResW'(1),
                                      sc_in[stok_pkg::CODE_W-1:0], 1'b0);
          n = n + 2'd1;
        end else begin
          res_d[n] = stok_pkg::mk_res(stok_pkg::K_ERROR, ResW'(pos_q), '0,
                                      stok_pkg::PC_NONE, last_i);
          n = n + 2'd1;
          done = 1'b1;
          if (last_i) begin
            wipe = 1'b1;
          end else begin
            mode_d   = M_IDLE;
            hvalid_d = 1'b0;
            halted_d = 1'b1;
          end
        end
      end

      if (!done) begin
        pos_d = p_inc;
        if (last_i) begin
          wipe = 1'b1;
          if (mode_d == M_CHAR || mode_d == M_STRING) begin
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_ERROR, ResW'(tstart_d - PosOne), '0,
                                        stok_pkg::PC_NONE, 1'b1);
            n = n + 2'd1;
          end else begin
            if (mode_d == M_PUNCT) begin
              sc_held = stok_pkg::single_code(hbyte_d);
              res_d[n] = stok_pkg::mk_res(stok_pkg::K_PUNCT, ResW'(tstart_d), ResW'(1),
                                          sc_held[stok_pkg::CODE_W-1:0], 1'b0);
              n = n + 2'd1;
            end else if (mode_d != M_IDLE) begin
              res_d[n] = stok_pkg::mk_res(word_kind(mode_d), ResW'(tstart_d),
                                          ResW'(p_inc - tstart_d), stok_pkg::PC_NONE, 1'b0);
              n = n + 2'd1;
            end
            res_d[n] = stok_pkg::mk_res(stok_pkg::K_END, ResW'(p_inc), '0,
                                        stok_pkg::PC_NONE, 1'b1);
            n = n + 2'd1;
          end
        end
      end
    end

    if (wipe) begin
      mode_d   = M_IDLE;
      pos_d    = '0;
      tstart_d = '0;
      hbyte_d  = '0;
      hvalid_d = 1'b0;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pos_q    <= '0;
      tstart_q <= '0;
      hbyte_q  <= '0;
      hvalid_q <= 1'b0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      hbyte_q  <= hbyte_d;
      hvalid_q <= hvalid_d;
      halted_q <= halted_d;
    end
  end

  assign res_o     = res_d;
  assign res_cnt_o = n;

endmodule

// ===== hdl/stok_resq.sv =====
// token queue taking up to three tokens per cycle and handing out one
module stok_resq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_cnt_i,
  input  stok_pkg::res_t [stok_pkg::RES_MAX-1:0] push_data_i,
  output logic                                room_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output stok_pkg::res_t                      out_data_o
);

  localparam int PtrW = stok_pkg::RQ_PTR_W;
  localparam int CntW = stok_pkg::RQ_CNT_W;

  stok_pkg::res_t mem_q [stok_pkg::RQ_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [CntW-1:0] kept;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign kept        = cnt_q - CntW'(pop);
  assign room_o      = kept <= CntW'(stok_pkg::RQ_DEPTH - stok_pkg::RES_MAX);

  assign wr_d  = wr_q + PtrW'(push_cnt_i);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = kept + CntW'(push_cnt_i);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < stok_pkg::RES_MAX; i++) begin
      if (2'(i) < push_cnt_i) begin
        mem_q[wr_q + PtrW'(i)] <= push_data_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sim/tb_source_tokenizer_top.sv =====
// self-checking testbench for the source tokenizer: byte streams in, tokens checked
`timescale 1ns / 100ps

module tb_source_tokenizer_top;

  localparam int PosW   = stok_pkg::POSITION_BITS;
  localparam int ResW   = stok_pkg::RES_W;
  localparam int CodeW  = stok_pkg::CODE_W;
  localparam int DataW  = stok_pkg::TDATA_W;

  typedef enum {
    SCAN_IDLE, SCAN_HEX, SCAN_BIN, SCAN_DEC, SCAN_WORD, SCAN_CHAR, SCAN_STR, SCAN_PUNCT
  } scan_e;

  localparam logic [PosW-1:0] POS_TOP = '1;

  class token_scoreboard_t;
    scan_e                    mode;
    logic [PosW-1:0]          pos;
    logic [PosW-1:0]          tok_start;
    logic [7:0]               held_ch;
    bit                       zero_int;
    bit                       halted;
    stok_pkg::res_t           tokens_due[$];
    int                       errors;
    int                       bytes_seen;

    function new();
      errors = 0;
      bytes_seen = 0;
      clear();
    endfunction

    function void clear();
      mode = SCAN_IDLE;
      pos = '0;
      tok_start = '0;
      held_ch = '0;
      zero_int = 0;
      halted = 0;
    endfunction

    function bit blank_ch(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function bit dec_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit word_ch(logic [7:0] c);
      return letter_ch(c) || dec_ch(c) || c == "_";
    endfunction

    function bit hex_ch(logic [7:0] c);
      return dec_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // 5..27 for a one-character punctuator, -1 otherwise
    function int punct_index(logic [7:0] c);
      string tbl = "<>+-/*%=;:,.[](){}!?&^|";
      for (int i = 0; i < tbl.len(); i++)
        if (tbl[i] == c) return i + 5;
      return -1;
    endfunction

    function void add_token(stok_pkg::kind_e k, logic [ResW-1:0] s, logic [ResW-1:0] l,
                            logic [CodeW-1:0] code, logic last);
      stok_pkg::res_t t;
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.code  = code;
      t.last  = last;
      tokens_due.push_back(t);
    endfunction

    function void close_word(logic [PosW-1:0] stop);
      stok_pkg::kind_e k;
      if (mode == SCAN_HEX || mode == SCAN_BIN) k = stok_pkg::K_PREFIXED;
      else if (mode == SCAN_DEC) k = stok_pkg::K_INT;
      else k = stok_pkg::K_IDENT;
      add_token(k, ResW'(tok_start), ResW'(stop - tok_start), stok_pkg::PC_NONE, 1'b0);
    endfunction

    function void scan_byte(logic [7:0] c, logic last);
      logic [PosW-1:0] p;
      bit taken;
      int code;
      p = pos;
      taken = 0;
      bytes_seen++;
      if (halted) begin
        if (last) begin
          add_token(stok_pkg::K_ERROR, ResW'(tok_start), '0, stok_pkg::PC_NONE, 1'b1);
          clear();
        end
        return;
      end
      if (p == POS_TOP) begin
        add_token(stok_pkg::K_ERROR, ResW'(p), '0, stok_pkg::PC_NONE, last);
        if (last) begin
          clear();
        end else begin
          mode = SCAN_IDLE;
          zero_int = 0;
          halted = 1;
          tok_start = p;
        end
        return;
      end
      case (mode)
        SCAN_HEX, SCAN_BIN, SCAN_DEC, SCAN_WORD: begin
          if (mode == SCAN_DEC && zero_int && (c == "x" || c == "b")) begin
            mode = (c == "x") ? SCAN_HEX : SCAN_BIN;
            taken = 1;
          end else if ((mode == SCAN_HEX && hex_ch(c)) ||
                       (mode == SCAN_BIN && (c == "0" || c == "1")) ||
                       (mode == SCAN_DEC && dec_ch(c)) ||
                       (mode == SCAN_WORD && word_ch(c))) begin
            taken = 1;
          end else begin
            close_word(p);
            mode = SCAN_IDLE;
          end
          zero_int = 0;
        end
        SCAN_CHAR, SCAN_STR: begin
          taken = 1;
          if (c == (mode == SCAN_CHAR ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE)) begin
            add_token(mode == SCAN_CHAR ? stok_pkg::K_CHAR : stok_pkg::K_STRING,
                      ResW'(tok_start), ResW'(p - tok_start), stok_pkg::PC_NONE, 1'b0);
            mode = SCAN_IDLE;
          end
        end
        SCAN_PUNCT: begin
          code = -1;
          if (held_ch == "-" && c == ">") code = int'(stok_pkg::PC_ARROW);
          else if (held_ch == "<" && c == "<") code = int'(stok_pkg::PC_SHL);
          else if (held_ch == ">" && c == ">") code = int'(stok_pkg::PC_SHR);
          else if (held_ch == "<" && c == "=") code = int'(stok_pkg::PC_LE);
          else if (held_ch == ">" && c == "=") code = int'(stok_pkg::PC_GE);
          if (code >= 0) begin
            add_token(stok_pkg::K_PUNCT, ResW'(tok_start), ResW'(2), CodeW'(code), 1'b0);
            taken = 1;
          end else begin
            add_token(stok_pkg::K_PUNCT, ResW'(tok_start), ResW'(1),
                      CodeW'(punct_index(held_ch)), 1'b0);
          end
          mode = SCAN_IDLE;
        end
        default: ;
      endcase

      if (!taken) begin
        tok_start = p;
        if (dec_ch(c)) begin
          mode = SCAN_DEC;
          zero_int = (c == "0");
        end else if (letter_ch(c) || c == "_") begin
          mode = SCAN_WORD;
        end else if (c == stok_pkg::CH_SQUOTE || c == stok_pkg::CH_DQUOTE) begin
          mode = (c == stok_pkg::CH_SQUOTE) ? SCAN_CHAR : SCAN_STR;
          tok_start = p + 1'b1;
        end else if (c == "-" || c == "<" || c == ">") begin
          mode = SCAN_PUNCT;
          held_ch = c;
        end else if (punct_index(c) >= 0) begin
          add_token(stok_pkg::K_PUNCT, ResW'(p), ResW'(1), CodeW'(punct_index(c)), 1'b0);
        end else if (!blank_ch(c)) begin
          add_token(stok_pkg::K_ERROR, ResW'(p), '0, stok_pkg::PC_NONE, last);
          if (last) begin
            clear();
          end else begin
            mode = SCAN_IDLE;
            zero_int = 0;
            halted = 1;
          end
          return;
        end
      end

      pos = p + 1'b1;
      if (last) begin
        if (mode == SCAN_CHAR || mode == SCAN_STR) begin
          add_token(stok_pkg::K_ERROR, ResW'(tok_start - 1'b1), '0, stok_pkg::PC_NONE, 1'b1);
        end else begin
          if (mode == SCAN_PUNCT) begin
            add_token(stok_pkg::K_PUNCT, ResW'(tok_start), ResW'(1),
                      CodeW'(punct_index(held_ch)), 1'b0);
          end else if (mode != SCAN_IDLE) begin
            close_word(p + 1'b1);
          end
          add_token(stok_pkg::K_END, ResW'(p + 1'b1), '0, stok_pkg::PC_NONE, 1'b1);
        end
        clear();
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_token(logic [2:0] kind, logic [DataW-1:0] data, logic last);
      stok_pkg::res_t t;
      if (tokens_due.size() == 0) begin
        report($sformatf("unexpected token kind %0d start %0d", kind, data[23:0]));
        return;
      end
      t = tokens_due.pop_front();
      if (kind != t.kind) report($sformatf("kind %0d, want %0d", kind, t.kind));
      if (data[23:0] != t.start) report($sformatf("start %0d, want %0d", data[23:0], t.start));
      if (data[47:24] != t.len) report($sformatf("length %0d, want %0d", data[47:24], t.len));
      if (data[52:48] != t.code) report($sformatf("code %0d, want %0d", data[52:48], t.code));
      if (data[DataW-1:53] != '0) report("nonzero pad bits in tdata");
      if (last != t.last) report($sformatf("tlast %0d, want %0d", last, t.last));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DataW-1:0]     m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  token_scoreboard_t sb = new();
  logic [7:0]        src_q[$];
  bit                calm = 1'b0;
  bit                long_hold_done = 1'b0;

  source_tokenizer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshakes are sampled mid-cycle, where every signal is settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.scan_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_random_token();
    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string digits = "0123456789";
    string hexes = "0123456789abcdefABCDEF";
    string pairs = "-><<>><=>=";
    string singles = "<>+-/*%=;:,.[](){}!?&^|";
    string blanks = "\t\n\v\f\r ";
    logic [7:0] b;
    int idx;
    case ($urandom_range(0, 19))
      0, 1: begin
        src_q.push_back("0");
        src_q.push_back("x");
        repeat ($urandom_range(0, 4)) src_q.push_back(pick(hexes));
      end
      2, 3: begin
        src_q.push_back("0");
        src_q.push_back("b");
        repeat ($urandom_range(0, 5)) src_q.push_back(pick("01"));
      end
      4, 5: repeat ($urandom_range(1, 5)) src_q.push_back(pick(digits));
      6, 7, 8: begin
        src_q.push_back(pick(letters));
        repeat ($urandom_range(0, 5)) src_q.push_back(pick({letters, digits}));
      end
      9, 10: begin
        src_q.push_back(stok_pkg::CH_SQUOTE);
        repeat ($urandom_range(0, 2)) begin
          do b = 8'($urandom_range(0, 255)); while (b == stok_pkg::CH_SQUOTE);
          src_q.push_back(b);
        end
        src_q.push_back(stok_pkg::CH_SQUOTE);
      end
      11, 12: begin
        src_q.push_back(stok_pkg::CH_DQUOTE);
        repeat ($urandom_range(0, 4)) begin
          do b = 8'($urandom_range(0, 255)); while (b == stok_pkg::CH_DQUOTE);
          src_q.push_back(b);
        end
        src_q.push_back(stok_pkg::CH_DQUOTE);
      end
      13, 14, 15, 16: begin
        if ($urandom_range(0, 1)) begin
          idx = $urandom_range(0, 4);
          src_q.push_back(pairs[2 * idx]);
          src_q.push_back(pairs[2 * idx + 1]);
        end else begin
          src_q.push_back(pick(singles));
        end
      end
      17, 18: repeat ($urandom_range(1, 3)) src_q.push_back(pick(blanks));
      default: src_q.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1)) src_q.push_back(pick(blanks));
  endfunction

  task automatic send_byte(logic [7:0] c, logic last);
    bit ok;
    int gap;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    gap = (!calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
  endtask

  task automatic send_stream();
    foreach (src_q[i]) send_byte(src_q[i], i == src_q.size() - 1);
  endtask

  initial begin
    forever begin
      repeat ($urandom_range(50, 200)) @(posedge clk_i);
      calm <= !calm;
    end
  end

  initial begin
    int hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && sb.bytes_seen >= 45) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) hold = idle_len();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // prefixed numbers, two-char punctuator, bare 0b closed by the last byte
    send_text("0xAf<<0b", 1'b1);
    // char literal holding a double quote, left open by the last byte
    send_text("'q\"s", 1'b1);
    // unknown byte halts; later bytes ignored until the last one
    send_text("_9 @ ", 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("->\t>=7", 1'b1);
    // unknown byte as the last byte
    send_byte(8'h80, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (sb.tokens_due.size() != 0) @(posedge clk_i);

    while (sb.bytes_seen < 110) begin
      src_q.delete();
      repeat ($urandom_range(1, 8)) add_random_token();
      if ($urandom_range(0, 9) == 0) begin
        src_q.push_back($urandom_range(0, 1) ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE);
        repeat ($urandom_range(0, 2)) src_q.push_back(pick("abc01 "));
      end
      send_stream();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.tokens_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.tokens_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
